// File: design/p2lf_pkg.sv
// ---------------------------------------------------------------------------
// p2lf_pkg
// Shared types and constants for the 3D point-to-line foot pipeline.
// ---------------------------------------------------------------------------
package p2lf_pkg;

	localparam int EPS_WIDTH = 16;
	localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;

	typedef struct packed {
		logic       deg;
		logic       nneg;
		logic [2:0] dneg;
	} flags_t;

endpackage

// File: design/point_to_line_foot_3d.sv
// ---------------------------------------------------------------------------
// point_to_line_foot_3d
// Foot of the perpendicular from point A onto the line through B and C.
// ---------------------------------------------------------------------------
// Accepts one point triple per cycle while the output does not stall and
// returns results in order through four front stages, two scaling stages,
// one divider stage per quotient bit (COORD_WIDTH + 2 of them), and the
// output register. The unrolled divider sets the latency.
// A stall at the output backs up stage by stage; empty stages keep filling.
module point_to_line_foot_3d #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// foot_x, foot_y, foot_z
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
	// degenerate, overflow
	output logic [1:0]                             m_axis_tuser,
	input  logic                                   cfg_we,
	input  logic [p2lf_pkg::EPS_WIDTH-1:0]         cfg_wdata
);
	localparam int W  = COORD_WIDTH;
	localparam int MW = W + 1;
	localparam int SW = 2 * MW + 2;
	localparam int XW = SW + MW;
	localparam int QB = W + 2;
	localparam int OW = ((3*W+7)/8)*8;

	logic [p2lf_pkg::EPS_WIDTH-1:0] eps_q;

	logic [2:0][W-1:0] a_w, b_w, c_w;

	logic               f_valid, f_ready;
	logic [SW-1:0]      f_num, f_den;
	logic [2:0][MW-1:0] f_dmag;
	logic [2:0][W-1:0]  f_b;
	p2lf_pkg::flags_t   f_flags;

	logic               s_valid, s_ready;
	logic [2:0][XW-1:0] s_x;
	logic [SW-1:0]      s_den;
	logic [2:0][W-1:0]  s_b;
	p2lf_pkg::flags_t   s_flags;

	logic               d_valid, d_ready;
	logic [2:0][QB-1:0] d_quo;
	logic [2:0][SW-1:0] d_rem;
	logic [SW-1:0]      d_den;
	logic [2:0][W-1:0]  d_b;
	p2lf_pkg::flags_t   d_flags;

	logic [2:0][W-1:0]  foot;
	logic               deg, ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= p2lf_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_w[i] = s_axis_tdata[i*W +: W];
			b_w[i] = s_axis_tdata[(3+i)*W +: W];
			c_w[i] = s_axis_tdata[(6+i)*W +: W];
		end
	end

	p2lf_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.a(a_w), .b(b_w), .c(c_w), .eps(eps_q),
		.out_valid(f_valid), .out_ready(f_ready),
		.num(f_num), .den(f_den), .dmag(f_dmag), .bout(f_b), .flags(f_flags)
	);

	p2lf_scale #(.W(W)) u_scale (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready),
		.num(f_num), .den(f_den), .dmag(f_dmag), .b(f_b), .flags(f_flags),
		.out_valid(s_valid), .out_ready(s_ready),
		.x(s_x), .den_out(s_den), .bout(s_b), .flags_out(s_flags)
	);

	p2lf_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_valid), .in_ready(s_ready),
		.x(s_x), .den(s_den), .b(s_b), .flags(s_flags),
		.out_valid(d_valid), .out_ready(d_ready),
		.quo(d_quo), .rem(d_rem), .den_out(d_den), .bout(d_b), .flags_out(d_flags)
	);

	p2lf_out #(.W(W)) u_out (
		.clk(clk), .arst_n(arst_n),
		.in_valid(d_valid), .in_ready(d_ready),
		.quo(d_quo), .rem(d_rem), .den(d_den), .b(d_b), .flags(d_flags),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.foot(foot), .degenerate(deg), .overflow(ovf)
	);

	assign m_axis_tdata = OW'(foot);
	assign m_axis_tuser = {ovf, deg};

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("degenerate and overflow both set");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	a_no_bubble_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("stalled result dropped");
endmodule

// File: design/p2lf_front.sv
// ---------------------------------------------------------------------------
// p2lf_front
// Differences, products, dot/norm sums and signed numerator; four stages.
// ---------------------------------------------------------------------------
module p2lf_front #(
	parameter int W = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0][W-1:0]                a,
	input  logic [2:0][W-1:0]                b,
	input  logic [2:0][W-1:0]                c,
	input  logic [p2lf_pkg::EPS_WIDTH-1:0]   eps,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2*(W+1)+1:0]               num,
	output logic [2*(W+1)+1:0]               den,
	output logic [2:0][W:0]                  dmag,
	output logic [2:0][W-1:0]                bout,
	output p2lf_pkg::flags_t                 flags
);
	localparam int MW = W + 1;
	localparam int PW = 2 * MW;
	localparam int SW = PW + 2;

	logic [4:1] v;
	logic [5:1] en;

	logic [2:0][MW-1:0] dm_s1, pm_s1;
	logic [2:0]         dn_s1, pn_s1;
	logic [2:0][W-1:0]  b_s1;
	logic               small_s1;

	logic [2:0][PW-1:0] pd_s2, dd_s2;
	logic [2:0]         pdn_s2, dn_s2;
	logic [2:0][MW-1:0] dm_s2;
	logic [2:0][W-1:0]  b_s2;
	logic               small_s2;

	logic [SW-1:0]      pos_s3, neg_s3, den_s3;
	logic [2:0]         dn_s3;
	logic [2:0][MW-1:0] dm_s3;
	logic [2:0][W-1:0]  b_s3;
	logic               deg_s3;

	logic [SW-1:0]      num_s4, den_s4;
	logic [2:0][MW-1:0] dm_s4;
	logic [2:0][W-1:0]  b_s4;
	p2lf_pkg::flags_t   fl_s4;

	logic [2:0][MW-1:0] d_w, p_w, dmag_w, pmag_w;
	logic [2:0]         dsmall_w;
	logic [SW-1:0]      pos_w, neg_w, den_w;
	logic               dz_w;

	always_comb begin
		en[5] = out_ready;
		for (int k = 4; k >= 1; k--) en[k] = !v[k] || en[k+1];
	end
	assign in_ready = en[1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_w[i] = {b[i][W-1], b[i]} - {c[i][W-1], c[i]};
			p_w[i] = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
			dmag_w[i] = d_w[i][W] ? -d_w[i] : d_w[i];
			pmag_w[i] = p_w[i][W] ? -p_w[i] : p_w[i];
			dsmall_w[i] = dmag_w[i] < MW'(eps);
		end
	end

	always_comb begin
		pos_w = '0;
		neg_w = '0;
		den_w = '0;
		dz_w  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (pdn_s2[i]) neg_w = neg_w + SW'(pd_s2[i]);
			else pos_w = pos_w + SW'(pd_s2[i]);
			den_w = den_w + SW'(dd_s2[i]);
			if (dm_s2[i] != '0) dz_w = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			for (int k = 2; k <= 4; k++) if (en[k]) v[k] <= v[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				dm_s1[i] <= dmag_w[i];
				pm_s1[i] <= pmag_w[i];
				dn_s1[i] <= d_w[i][W];
				pn_s1[i] <= p_w[i][W];
			end
			b_s1     <= b;
			small_s1 <= &dsmall_w;
		end
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[i]  <= pm_s1[i] * dm_s1[i];
				dd_s2[i]  <= dm_s1[i] * dm_s1[i];
				pdn_s2[i] <= pn_s1[i] ^ dn_s1[i];
			end
			dn_s2    <= dn_s1;
			dm_s2    <= dm_s1;
			b_s2     <= b_s1;
			small_s2 <= small_s1;
		end
		if (en[3]) begin
			pos_s3 <= pos_w;
			neg_s3 <= neg_w;
			den_s3 <= den_w;
			dn_s3  <= dn_s2;
			dm_s3  <= dm_s2;
			b_s3   <= b_s2;
			deg_s3 <= small_s2 || dz_w;
		end
		if (en[4]) begin
			if (pos_s3 >= neg_s3) begin
				num_s4 <= pos_s3 - neg_s3;
			end else begin
				num_s4 <= neg_s3 - pos_s3;
			end
			fl_s4.nneg <= pos_s3 < neg_s3;
			fl_s4.deg  <= deg_s3;
			fl_s4.dneg <= dn_s3;
			den_s4     <= den_s3;
			dm_s4      <= dm_s3;
			b_s4       <= b_s3;
		end
	end

	assign out_valid = v[4];
	assign num   = num_s4;
	assign den   = den_s4;
	assign dmag  = dm_s4;
	assign bout  = b_s4;
	assign flags = fl_s4;
endmodule

// File: design/p2lf_scale.sv
// ---------------------------------------------------------------------------
// p2lf_scale
// Numerator times each direction magnitude, split in two partial products.
// ---------------------------------------------------------------------------
module p2lf_scale #(
	parameter int W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2*(W+1)+1:0]           num,
	input  logic [2*(W+1)+1:0]           den,
	input  logic [2:0][W:0]              dmag,
	input  logic [2:0][W-1:0]            b,
	input  p2lf_pkg::flags_t             flags,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0][3*(W+1)+1:0]      x,
	output logic [2*(W+1)+1:0]           den_out,
	output logic [2:0][W-1:0]            bout,
	output p2lf_pkg::flags_t             flags_out
);
	localparam int MW = W + 1;
	localparam int NW = 2 * MW + 2;
	localparam int NL = MW;
	localparam int NH = NW - NL;
	localparam int XW = NW + MW;

	logic [2:1] v;
	logic [3:1] en;

	logic [2:0][NL+MW-1:0] lo_s1;
	logic [2:0][NH+MW-1:0] hi_s1;
	logic [NW-1:0]         den_s1, den_s2;
	logic [2:0][W-1:0]     b_s1, b_s2;
	p2lf_pkg::flags_t      fl_s1, fl_s2;
	logic [2:0][XW-1:0]    x_s2;

	assign en[3] = out_ready;
	assign en[2] = !v[2] || en[3];
	assign en[1] = !v[1] || en[2];
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			if (en[2]) v[2] <= v[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				lo_s1[i] <= num[NL-1:0] * dmag[i];
				hi_s1[i] <= num[NW-1:NL] * dmag[i];
			end
			den_s1 <= den;
			b_s1   <= b;
			fl_s1  <= flags;
		end
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				x_s2[i] <= XW'(lo_s1[i]) + (XW'(hi_s1[i]) << NL);
			end
			den_s2 <= den_s1;
			b_s2   <= b_s1;
			fl_s2  <= fl_s1;
		end
	end

	assign out_valid = v[2];
	assign x         = x_s2;
	assign den_out   = den_s2;
	assign bout      = b_s2;
	assign flags_out = fl_s2;
endmodule

// File: design/p2lf_div.sv
// ---------------------------------------------------------------------------
// p2lf_div
// Restoring divider, one quotient bit per stage, three lanes in parallel.
// ---------------------------------------------------------------------------
module p2lf_div #(
	parameter int W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0][3*(W+1)+1:0]      x,
	input  logic [2*(W+1)+1:0]           den,
	input  logic [2:0][W-1:0]            b,
	input  p2lf_pkg::flags_t             flags,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0][W+1:0]            quo,
	output logic [2:0][2*(W+1)+1:0]      rem,
	output logic [2*(W+1)+1:0]           den_out,
	output logic [2:0][W-1:0]            bout,
	output p2lf_pkg::flags_t             flags_out
);
	localparam int MW = W + 1;
	localparam int SW = 2 * MW + 2;
	localparam int XW = SW + MW;
	localparam int QB = W + 2;
	localparam int CW = SW + QB;

	logic [QB:0]          v;
	logic [QB+1:1]        en;
	logic [2:0][XW-1:0]   rem_s [0:QB];
	logic [2:0][QB-1:0]   q_s   [0:QB];
	logic [SW-1:0]        den_s [0:QB];
	logic [2:0][W-1:0]    b_s   [0:QB];
	p2lf_pkg::flags_t     fl_s  [0:QB];

	assign v[0]     = in_valid;
	assign rem_s[0] = x;
	assign q_s[0]   = '0;
	assign den_s[0] = den;
	assign b_s[0]   = b;
	assign fl_s[0]  = flags;
	assign en[QB+1] = out_ready;
	assign in_ready = en[1];

	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int K = QB - 1 - j;
		logic [CW-1:0]      sh;
		logic [2:0]         ge;
		logic [2:0][CW-1:0] diff;

		assign en[j+1] = !v[j+1] || en[j+2];
		assign sh = CW'(den_s[j]) << K;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i]   = CW'(rem_s[j][i]) >= sh;
				diff[i] = CW'(rem_s[j][i]) - sh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[j+1] <= 1'b0;
			end else if (en[j+1]) begin
				v[j+1] <= v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j+1][i] <= ge[i] ? diff[i][XW-1:0] : rem_s[j][i];
					q_s[j+1][i]   <= {q_s[j][i][QB-2:0], ge[i]};
				end
				den_s[j+1] <= den_s[j];
				b_s[j+1]   <= b_s[j];
				fl_s[j+1]  <= fl_s[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) rem[i] = rem_s[QB][i][SW-1:0];
	end

	assign out_valid = v[QB];
	assign quo       = q_s[QB];
	assign den_out   = den_s[QB];
	assign bout      = b_s[QB];
	assign flags_out = fl_s[QB];
endmodule

// File: design/p2lf_out.sv
// ---------------------------------------------------------------------------
// p2lf_out
// Rounding, offset from B, saturation and the output register.
// ---------------------------------------------------------------------------
module p2lf_out #(
	parameter int W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0][W+1:0]            quo,
	input  logic [2:0][2*(W+1)+1:0]      rem,
	input  logic [2*(W+1)+1:0]           den,
	input  logic [2:0][W-1:0]            b,
	input  p2lf_pkg::flags_t             flags,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0][W-1:0]            foot,
	output logic                         degenerate,
	output logic                         overflow
);
	localparam int QB = W + 2;
	localparam int FW = W + 4;

	logic               v_q;
	logic               en;
	logic [2:0][W-1:0]  foot_q;
	logic               deg_q, ovf_q;

	logic [2:0][FW-1:0] f_w;
	logic [2:0][QB:0]   mag_w;
	logic [2:0][W-1:0]  sat_w;
	logic [2:0]         ovf_w;

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_w[i] = (QB+1)'(quo[i]) + (QB+1)'({rem[i], 1'b0} >= {1'b0, den});
			if (flags.nneg ^ flags.dneg[i]) begin
				f_w[i] = FW'($signed(b[i])) - FW'(mag_w[i]);
			end else begin
				f_w[i] = FW'($signed(b[i])) + FW'(mag_w[i]);
			end
			ovf_w[i] = !((&f_w[i][FW-1:W-1]) || !(|f_w[i][FW-1:W-1]));
			if (ovf_w[i]) begin
				sat_w[i] = f_w[i][FW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				sat_w[i] = f_w[i][W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (flags.deg) begin
				foot_q <= b;
				ovf_q  <= 1'b0;
			end else begin
				foot_q <= sat_w;
				ovf_q  <= |ovf_w;
			end
			deg_q <= flags.deg;
		end
	end

	assign out_valid  = v_q;
	assign foot       = foot_q;
	assign degenerate = deg_q;
	assign overflow   = ovf_q;
endmodule
